@@ sv/ilc_pkg.sv @@
// Shared types and constants for the indexed list with cursor.
// Used by ilc_dp, ilc_ctrl and indexed_list_with_cursor; no dependencies.
package ilc_pkg;

    localparam int CAPACITY   = 64;
    localparam int ENTRY_BITS = 32;
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    typedef logic [ENTRY_BITS-1:0] t_entry;
    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [COUNT_BITS-1:0] t_count;

    // Operation codes of a request
    typedef enum logic [2:0] {
        FN_PREPEND = 3'd0,
        FN_APPEND  = 3'd1,
        FN_REMOVE  = 3'd2,
        FN_GET     = 3'd3,
        FN_FIRST   = 3'd4,
        FN_LAST    = 3'd5,
        FN_NEXT    = 3'd6,
        FN_PREV    = 3'd7
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ_WAIT,
        S_REM_READ,
        S_REM_SHIFT,
        S_SHIFT_UP,
        S_INSERT_HEAD,
        S_FINISH
    } t_state;

    // Read address source
    typedef enum logic [2:0] {
        RD_ZERO,
        RD_POS,
        RD_POS_P1,
        RD_CUR,
        RD_CUR_M1,
        RD_CNT_M1,
        RD_IDX_M2,
        RD_IDX_P2
    } t_rd_sel;

    // Write port operation
    typedef enum logic [1:0] {
        WR_NONE,
        WR_APPEND,
        WR_HEAD,
        WR_SHIFT
    } t_wr_op;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CNT,
        IDX_POS,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ONE,
        CUR_CNT,
        CUR_INC,
        CUR_DEC
    } t_cur_op;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_OK0,
        RES_NONE,
        RES_FULL,
        RES_READ
    } t_res_op;

    // Controller to datapath
    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        t_rd_sel rd_sel;
        t_wr_op  wr_op;
        t_idx_op idx_op;
        t_cnt_op cnt_op;
        t_cur_op cur_op;
        t_res_op res_op;
        logic    emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_func func;
        logic  list_empty;
        logic  list_full;
        logic  pos_out;
        logic  cur_end;
        logic  cur_low;
        logic  pos_next_in;
        logic  idx_next_in;
        logic  idx_gt1;
        logic  out_free;
    } t_stat;

endpackage

@@ sv/indexed_list_with_cursor.sv @@
// Top level of the indexed list with cursor: joins controller and datapath.
// Depends on ilc_pkg, ilc_ctrl, ilc_dp (which holds ilc_ram).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: i_func
//   (prepend, append, remove, get, first, last, next, prev), i_position
//   for remove and get, and i_entry_in for inserts. Output channel
//   (o_out_valid / i_out_stall) returns exactly one result per request:
//   o_entry_out, o_status (ok, none, full) and o_entry_count.
//   A request is taken only while the block is idle; one request is in
//   work at a time. Entries live in a single-port-write, registered-read
//   RAM, so reads and entry shifts are done one after another: a
//   successful prepend moves every entry up a place, and a successful
//   remove at pos moves every entry after pos down a place.
//   A new request is accepted the cycle after its predecessor's result is
//   loaded, even while that result still waits in the output register.
//   If the receiver stalls, the finished result waits in the result
//   register until the output register frees up. Reset empties the
//   list and zeroes the cursor and count; RAM contents are not cleared.
module indexed_list_with_cursor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [2:0]                     i_func,
    input  logic [ilc_pkg::ADDR_BITS-1:0]  i_position,
    input  logic [ilc_pkg::ENTRY_BITS-1:0] i_entry_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ilc_pkg::ENTRY_BITS-1:0] o_entry_out,
    output logic [1:0]                     o_status,
    output logic [ilc_pkg::COUNT_BITS-1:0] o_entry_count
);

    ilc_pkg::t_cmd  cmd;
    ilc_pkg::t_stat stat;

    ilc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ilc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_entry_in    (i_entry_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_entry_out   (o_entry_out),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule

@@ sv/ilc_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ilc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ilc_dp.sv @@
// Datapath of the indexed list: request registers, count, cursor, walk index,
// entry RAM and result register. Depends on ilc_pkg and ilc_ram.
module ilc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ilc_pkg::t_cmd                      i_cmd,
    output ilc_pkg::t_stat                     o_stat,
    input  logic [2:0]                         i_func,
    input  logic [ilc_pkg::ADDR_BITS-1:0]      i_position,
    input  logic [ilc_pkg::ENTRY_BITS-1:0]     i_entry_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ilc_pkg::ENTRY_BITS-1:0]     o_entry_out,
    output logic [1:0]                         o_status,
    output logic [ilc_pkg::COUNT_BITS-1:0]     o_entry_count
);

    localparam int AB = ilc_pkg::ADDR_BITS;
    localparam int CB = ilc_pkg::COUNT_BITS;

    // Request registers
    ilc_pkg::t_func   r_func;
    ilc_pkg::t_addr   r_pos;
    ilc_pkg::t_entry  r_item;

    // List state
    ilc_pkg::t_count  r_count;
    ilc_pkg::t_count  r_cursor;
    ilc_pkg::t_addr   r_idx;

    // Result being built
    ilc_pkg::t_entry  r_value;
    ilc_pkg::t_status r_res_status;

    // Output register
    logic             r_out_valid;
    ilc_pkg::t_entry  r_out_entry;
    ilc_pkg::t_status r_out_status;
    ilc_pkg::t_count  r_out_count;

    // RAM ports
    logic            ram_we;
    ilc_pkg::t_addr  ram_waddr;
    ilc_pkg::t_entry ram_wdata;
    ilc_pkg::t_addr  ram_raddr;
    ilc_pkg::t_entry ram_rdata;

    logic            out_free;

    ilc_ram #(
        .WIDTH (ilc_pkg::ENTRY_BITS),
        .DEPTH (ilc_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Read address select
    always_comb begin
        case (i_cmd.rd_sel)
            ilc_pkg::RD_ZERO:   ram_raddr = '0;
            ilc_pkg::RD_POS:    ram_raddr = r_pos;
            ilc_pkg::RD_POS_P1: ram_raddr = r_pos + AB'(1);
            ilc_pkg::RD_CUR:    ram_raddr = r_cursor[AB-1:0];
            ilc_pkg::RD_CUR_M1: ram_raddr = AB'(r_cursor - CB'(1));
            ilc_pkg::RD_CNT_M1: ram_raddr = AB'(r_count - CB'(1));
            ilc_pkg::RD_IDX_M2: ram_raddr = r_idx - AB'(2);
            ilc_pkg::RD_IDX_P2: ram_raddr = r_idx + AB'(2);
            default:            ram_raddr = '0;
        endcase
    end

    // Write port select
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_item;
        case (i_cmd.wr_op)
            ilc_pkg::WR_NONE: begin
                ram_we = 1'b0;
            end
            ilc_pkg::WR_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[AB-1:0];
            end
            ilc_pkg::WR_HEAD: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
            end
            ilc_pkg::WR_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Status for the controller
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.func        = r_func;
        o_stat.list_empty  = (r_count == '0);
        o_stat.list_full   = (r_count == CB'(ilc_pkg::CAPACITY));
        o_stat.pos_out     = (CB'(r_pos) >= r_count);
        o_stat.cur_end     = (r_cursor >= r_count);
        o_stat.cur_low     = (r_cursor <= CB'(1));
        o_stat.pos_next_in = ((CB'(r_pos) + CB'(1)) < r_count);
        o_stat.idx_next_in = ((CB'(r_idx) + CB'(1)) < r_count);
        o_stat.idx_gt1     = (r_idx > AB'(1));
        o_stat.out_free    = out_free;
    end

    // Request capture and result build (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_func <= ilc_pkg::t_func'(i_func);
            r_pos  <= i_position;
            r_item <= i_entry_in;
        end

        case (i_cmd.idx_op)
            ilc_pkg::IDX_HOLD: r_idx <= r_idx;
            ilc_pkg::IDX_CNT:  r_idx <= r_count[AB-1:0];
            ilc_pkg::IDX_POS:  r_idx <= r_pos;
            ilc_pkg::IDX_INC:  r_idx <= r_idx + AB'(1);
            ilc_pkg::IDX_DEC:  r_idx <= r_idx - AB'(1);
            default:           r_idx <= r_idx;
        endcase

        case (i_cmd.res_op)
            ilc_pkg::RES_HOLD: begin
                r_value <= r_value;
            end
            ilc_pkg::RES_OK0: begin
                r_value      <= '0;
                r_res_status <= ilc_pkg::ST_OK;
            end
            ilc_pkg::RES_NONE: begin
                r_value      <= '0;
                r_res_status <= ilc_pkg::ST_NONE;
            end
            ilc_pkg::RES_FULL: begin
                r_value      <= '0;
                r_res_status <= ilc_pkg::ST_FULL;
            end
            ilc_pkg::RES_READ: begin
                r_value      <= ram_rdata;
                r_res_status <= ilc_pkg::ST_OK;
            end
            default: begin
                r_value <= r_value;
            end
        endcase

        if (i_cmd.emit) begin
            r_out_entry  <= r_value;
            r_out_status <= r_res_status;
            r_out_count  <= r_count;
        end
    end

    // Count, cursor and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.cnt_op)
                ilc_pkg::CNT_HOLD: r_count <= r_count;
                ilc_pkg::CNT_INC:  r_count <= r_count + CB'(1);
                ilc_pkg::CNT_DEC:  r_count <= r_count - CB'(1);
                default:           r_count <= r_count;
            endcase

            case (i_cmd.cur_op)
                ilc_pkg::CUR_HOLD: r_cursor <= r_cursor;
                ilc_pkg::CUR_ONE:  r_cursor <= CB'(1);
                ilc_pkg::CUR_CNT:  r_cursor <= r_count;
                ilc_pkg::CUR_INC:  r_cursor <= r_cursor + CB'(1);
                ilc_pkg::CUR_DEC:  r_cursor <= r_cursor - CB'(1);
                default:           r_cursor <= r_cursor;
            endcase

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_out   = r_out_entry;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    // Count and cursor never pass capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(ilc_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= CB'(ilc_pkg::CAPACITY))
        else $error("cursor above capacity");

    // A result is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result overwrote a pending output");

    // Failed operations carry a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ilc_pkg::ST_OK)) |-> (r_out_entry == '0))
        else $error("non-ok result with nonzero entry");

endmodule

@@ sv/ilc_ctrl.sv @@
// Controller state machine of the indexed list: sequences each request
// through RAM reads and entry shifts. Depends on ilc_pkg.
module ilc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ilc_pkg::t_stat i_stat,
    output ilc_pkg::t_cmd  o_cmd
);

    ilc_pkg::t_state r_state;
    ilc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ilc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ilc_pkg::S_IDLE);

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd.load_req  = 1'b0;
        o_cmd.rd_en     = 1'b0;
        o_cmd.rd_sel    = ilc_pkg::RD_ZERO;
        o_cmd.wr_op     = ilc_pkg::WR_NONE;
        o_cmd.idx_op    = ilc_pkg::IDX_HOLD;
        o_cmd.cnt_op    = ilc_pkg::CNT_HOLD;
        o_cmd.cur_op    = ilc_pkg::CUR_HOLD;
        o_cmd.res_op    = ilc_pkg::RES_HOLD;
        o_cmd.emit      = 1'b0;

        case (r_state)
            ilc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = ilc_pkg::S_EXEC;
                end
            end

            // Decode the request against count and cursor
            ilc_pkg::S_EXEC: begin
                n_state = ilc_pkg::S_FINISH;
                case (i_stat.func)
                    ilc_pkg::FN_PREPEND: begin
                        if (i_stat.list_full) begin
                            o_cmd.res_op = ilc_pkg::RES_FULL;
                        end else if (i_stat.list_empty) begin
                            o_cmd.wr_op  = ilc_pkg::WR_HEAD;
                            o_cmd.cnt_op = ilc_pkg::CNT_INC;
                            o_cmd.res_op = ilc_pkg::RES_OK0;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ilc_pkg::RD_CNT_M1;
                            o_cmd.idx_op = ilc_pkg::IDX_CNT;
                            n_state      = ilc_pkg::S_SHIFT_UP;
                        end
                    end
                    ilc_pkg::FN_APPEND: begin
                        if (i_stat.list_full) begin
                            o_cmd.res_op = ilc_pkg::RES_FULL;
                        end else begin
                            o_cmd.wr_op  = ilc_pkg::WR_APPEND;
                            o_cmd.cnt_op = ilc_pkg::CNT_INC;
                            o_cmd.res_op = ilc_pkg::RES_OK0;
                        end
                    end
                    ilc_pkg::FN_REMOVE: begin
                        if (i_stat.pos_out) begin
                            o_cmd.res_op = ilc_pkg::RES_NONE;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ilc_pkg::RD_POS;
                            n_state      = ilc_pkg::S_REM_READ;
                        end
                    end
                    ilc_pkg::FN_GET: begin
                        if (i_stat.pos_out) begin
                            o_cmd.res_op = ilc_pkg::RES_NONE;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ilc_pkg::RD_POS;
                            n_state      = ilc_pkg::S_READ_WAIT;
                        end
                    end
                    ilc_pkg::FN_FIRST: begin
                        // cursor moves to one even on an empty list
                        o_cmd.cur_op = ilc_pkg::CUR_ONE;
                        if (i_stat.list_empty) begin
                            o_cmd.res_op = ilc_pkg::RES_NONE;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ilc_pkg::RD_ZERO;
                            n_state      = ilc_pkg::S_READ_WAIT;
                        end
                    end
                    ilc_pkg::FN_LAST: begin
                        if (i_stat.list_empty) begin
                            o_cmd.res_op = ilc_pkg::RES_NONE;
                        end else begin
                            o_cmd.cur_op = ilc_pkg::CUR_CNT;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ilc_pkg::RD_CNT_M1;
                            n_state      = ilc_pkg::S_READ_WAIT;
                        end
                    end
                    ilc_pkg::FN_NEXT: begin
                        if (i_stat.cur_end) begin
                            o_cmd.res_op = ilc_pkg::RES_NONE;
                        end else begin
                            o_cmd.cur_op = ilc_pkg::CUR_INC;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ilc_pkg::RD_CUR;
                            n_state      = ilc_pkg::S_READ_WAIT;
                        end
                    end
                    ilc_pkg::FN_PREV: begin
                        if (i_stat.cur_low) begin
                            o_cmd.res_op = ilc_pkg::RES_NONE;
                        end else begin
                            o_cmd.cur_op = ilc_pkg::CUR_DEC;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ilc_pkg::RD_CUR_M1;
                            n_state      = ilc_pkg::S_READ_WAIT;
                        end
                    end
                    default: begin
                        o_cmd.res_op = ilc_pkg::RES_NONE;
                    end
                endcase
            end

            // Single read result
            ilc_pkg::S_READ_WAIT: begin
                o_cmd.res_op = ilc_pkg::RES_READ;
                n_state      = ilc_pkg::S_FINISH;
            end

            // Removed entry is out; start pulling later entries down
            ilc_pkg::S_REM_READ: begin
                o_cmd.res_op = ilc_pkg::RES_READ;
                o_cmd.cnt_op = ilc_pkg::CNT_DEC;
                if (i_stat.pos_next_in) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ilc_pkg::RD_POS_P1;
                    o_cmd.idx_op = ilc_pkg::IDX_POS;
                    n_state      = ilc_pkg::S_REM_SHIFT;
                end else begin
                    n_state = ilc_pkg::S_FINISH;
                end
            end

            // One entry moves down a place per cycle
            ilc_pkg::S_REM_SHIFT: begin
                o_cmd.wr_op = ilc_pkg::WR_SHIFT;
                if (i_stat.idx_next_in) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ilc_pkg::RD_IDX_P2;
                    o_cmd.idx_op = ilc_pkg::IDX_INC;
                end else begin
                    n_state = ilc_pkg::S_FINISH;
                end
            end

            // One entry moves up a place per cycle, top first
            ilc_pkg::S_SHIFT_UP: begin
                o_cmd.wr_op = ilc_pkg::WR_SHIFT;
                if (i_stat.idx_gt1) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ilc_pkg::RD_IDX_M2;
                    o_cmd.idx_op = ilc_pkg::IDX_DEC;
                end else begin
                    n_state = ilc_pkg::S_INSERT_HEAD;
                end
            end

            ilc_pkg::S_INSERT_HEAD: begin
                o_cmd.wr_op  = ilc_pkg::WR_HEAD;
                o_cmd.cnt_op = ilc_pkg::CNT_INC;
                o_cmd.res_op = ilc_pkg::RES_OK0;
                n_state      = ilc_pkg::S_FINISH;
            end

            // Hand the result to the output register
            ilc_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ilc_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ilc_pkg::S_IDLE;
            end
        endcase
    end

    // Requests are only taken in idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_req |-> (r_state == ilc_pkg::S_IDLE))
        else $error("request loaded outside idle");

    // Every accepted request leads to the decode state
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_req |=> (r_state == ilc_pkg::S_EXEC))
        else $error("accepted request not decoded");

    // A result is emitted only from the finish state, and returns to idle
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == ilc_pkg::S_IDLE))
        else $error("emit did not return to idle");

endmodule
